>>> rtl/core/dmbm_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the display mode best-match block.
package dmbm_pkg;

	localparam int MAX_MODES_DEF = 64;
	// Stored mode dimensions; equal to the width of the dimension ports.
	localparam int DIM_BITS      = 16;
	localparam int AREA_W        = 2 * DIM_BITS;
	localparam int UNI_W         = AREA_W + 1;
	localparam int PROD_W        = AREA_W + UNI_W;
	localparam int SLOT_W        = 6;
	localparam int CNT_REG_W     = 7;
	localparam int APB_AW        = 4;
	localparam int APB_DW        = 32;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		REG_MODE_COUNT = 2'd0,
		REG_HOST_MAX_W = 2'd1,
		REG_HOST_MAX_H = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] w;
		logic [DIM_BITS-1:0] h;
	} mode_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] w;
		logic [DIM_BITS-1:0] h;
		logic [AREA_W-1:0]   area;
	} query_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] max_w;
		logic [DIM_BITS-1:0] max_h;
	} host_lim_t;

	typedef struct packed {
		logic clr;
		logic valid_s1;
	} scan_ctl_t;

	typedef struct packed {
		logic found;
		logic pipe_busy;
	} scan_sts_t;

endpackage

>>> rtl/core/dmbm_mem.sv
`timescale 1ns / 1ps
// Mode table: single-port synchronous RAM with a registered read.
module dmbm_mem import dmbm_pkg::*; #(
	parameter int DEPTH = MAX_MODES_DEF,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [IDX_W-1:0] addr,
	input  mode_t            wr_data,
	output mode_t            rd_data
);

	mode_t mem [DEPTH];
	mode_t rd_data_q;

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en && !we) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/dmbm_score.sv
`timescale 1ns / 1ps
// Scoring pipeline: skip/exact check, IoU terms, cross-product compare, best tracking.
module dmbm_score import dmbm_pkg::*; #(
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctl_t        ctl,
	input  logic [IDX_W-1:0] idx_s1,
	input  mode_t            entry,
	input  query_t           req,
	input  host_lim_t        lim,
	output scan_sts_t        sts,
	output logic [IDX_W-1:0] chosen_idx
);

	logic                skip;
	logic                exact;
	logic [DIM_BITS-1:0] min_w;
	logic [DIM_BITS-1:0] min_h;

	logic                v_s2, v_s3, v_s4;
	logic [AREA_W-1:0]   inter_s2, ae_s2, inter_s3, inter_s4;
	logic [UNI_W-1:0]    uni_s3, uni_s4;
	logic [PROD_W-1:0]   p1_s4, p2_s4;
	logic [IDX_W-1:0]    idx_s2, idx_s3, idx_s4;

	logic                found_q;
	logic [IDX_W-1:0]    exact_idx_q;
	logic [AREA_W-1:0]   best_i_q;
	logic [UNI_W-1:0]    best_u_q;
	logic [IDX_W-1:0]    best_idx_q;

	assign skip  = (entry.w > lim.max_w) || (entry.h > lim.max_h) ||
	               (entry.w == '0) || (entry.h == '0);
	assign exact = !skip && (entry.w == req.w) && (entry.h == req.h);
	assign min_w = (entry.w < req.w) ? entry.w : req.w;
	assign min_h = (entry.h < req.h) ? entry.h : req.h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			found_q    <= 1'b0;
			best_i_q   <= '0;
			best_u_q   <= UNI_W'(1);
			best_idx_q <= '0;
		end else begin
			v_s2 <= ctl.valid_s1 && !skip && !exact && !found_q;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (ctl.clr) begin
				found_q    <= 1'b0;
				best_i_q   <= '0;
				best_u_q   <= UNI_W'(1);
				best_idx_q <= '0;
			end else begin
				if (ctl.valid_s1 && exact && !found_q) begin
					found_q <= 1'b1;
				end
				// strict greater-than keeps the earliest entry on ties
				if (v_s4 && !found_q && (p1_s4 > p2_s4)) begin
					best_i_q   <= inter_s4;
					best_u_q   <= uni_s4;
					best_idx_q <= idx_s4;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid_s1 && exact && !found_q) begin
			exact_idx_q <= idx_s1;
		end
		inter_s2 <= AREA_W'(min_w) * AREA_W'(min_h);
		ae_s2    <= AREA_W'(entry.w) * AREA_W'(entry.h);
		idx_s2   <= idx_s1;
		uni_s3   <= UNI_W'(ae_s2) + UNI_W'(req.area) - UNI_W'(inter_s2);
		inter_s3 <= inter_s2;
		idx_s3   <= idx_s2;
		// entries are issued only while phase_q is low, so best is current here
		p1_s4    <= PROD_W'(inter_s3) * PROD_W'(best_u_q);
		p2_s4    <= PROD_W'(best_i_q) * PROD_W'(uni_s3);
		inter_s4 <= inter_s3;
		uni_s4   <= uni_s3;
		idx_s4   <= idx_s3;
	end

	assign sts.found     = found_q;
	assign sts.pipe_busy = v_s2 || v_s3 || v_s4;
	assign chosen_idx    = found_q ? exact_idx_q : best_idx_q;

`ifndef SYNTHESIS
	a_iou_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		UNI_W'(best_i_q) <= best_u_q)
		else $error("best score exceeds one");
	a_clr_resets: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |=> (!found_q && best_idx_q == '0 && best_i_q == '0))
		else $error("query start did not clear best");
	a_found_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> $past(ctl.valid_s1))
		else $error("exact hit without an entry word");
	a_best_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(v_s4) && !$past(ctl.clr)) |-> $stable(best_i_q))
		else $error("best changed without a scored entry");
`endif

endmodule

>>> rtl/core/dmbm_seq.sv
`timescale 1ns / 1ps
// Sequencer: command accept, table writes, scan address issue, result register.
module dmbm_seq import dmbm_pkg::*; #(
	parameter int MAX_MODES = MAX_MODES_DEF,
	parameter int IDX_W     = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic [SLOT_W-1:0]    entry_index,
	input  logic [DIM_BITS-1:0]  width,
	input  logic [DIM_BITS-1:0]  height,
	input  logic [CNT_REG_W-1:0] mode_count,
	output logic                 mem_en,
	output logic                 mem_we,
	output logic [IDX_W-1:0]     mem_addr,
	output mode_t                mem_wdata,
	input  mode_t                rd_data,
	output scan_ctl_t            ctl,
	output logic [IDX_W-1:0]     idx_s1,
	output query_t               req,
	input  scan_sts_t            sts,
	input  logic [IDX_W-1:0]     chosen_idx,
	output logic                 result_valid,
	output logic [SLOT_W-1:0]    mode_index,
	output logic [DIM_BITS-1:0]  chosen_width,
	output logic [DIM_BITS-1:0]  chosen_height,
	output logic                 exact_hit
);

	localparam int CNT_W = $clog2(MAX_MODES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_RESULT
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic [CNT_W-1:0]     n_q;
	logic                 phase_q;
	logic                 valid_s1_q;
	logic [IDX_W-1:0]     idx_s1_q;
	query_t               req_q;
	logic                 result_valid_q;
	logic [SLOT_W-1:0]    mode_index_q;
	logic [DIM_BITS-1:0]  chosen_width_q;
	logic [DIM_BITS-1:0]  chosen_height_q;
	logic                 exact_hit_q;

	logic                 accept;
	logic                 is_query;
	logic                 slot_ok;
	logic                 issue;
	logic [CNT_W-1:0]     n_sat;

	assign accept   = start && (state_q == ST_IDLE);
	assign is_query = (req_type == REQ_QUERY);
	assign slot_ok  = int'(entry_index) < MAX_MODES;
	assign n_sat    = (int'(mode_count) > MAX_MODES) ? CNT_W'(MAX_MODES) : CNT_W'(mode_count);
	// one entry only while phase_q is low: matches the compare loop in the scorer
	assign issue    = (state_q == ST_SCAN) && !phase_q && (rd_idx_q < n_q) && !sts.found;

	always_comb begin
		mem_en   = 1'b0;
		mem_we   = 1'b0;
		mem_addr = rd_idx_q[IDX_W-1:0];
		if (accept && !is_query) begin
			mem_en   = slot_ok;
			mem_we   = 1'b1;
			mem_addr = IDX_W'(entry_index);
		end else if (issue) begin
			mem_en = 1'b1;
		end else if (state_q == ST_FETCH) begin
			mem_en   = 1'b1;
			mem_addr = chosen_idx;
		end
	end

	assign mem_wdata.w = width;
	assign mem_wdata.h = height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			rd_idx_q        <= '0;
			n_q             <= '0;
			phase_q         <= 1'b0;
			valid_s1_q      <= 1'b0;
			idx_s1_q        <= '0;
			req_q           <= '0;
			result_valid_q  <= 1'b0;
			mode_index_q    <= '0;
			chosen_width_q  <= '0;
			chosen_height_q <= '0;
			exact_hit_q     <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			valid_s1_q     <= issue;
			idx_s1_q       <= rd_idx_q[IDX_W-1:0];
			case (state_q)
				ST_IDLE: begin
					if (accept && is_query) begin
						state_q    <= ST_SCAN;
						n_q        <= n_sat;
						rd_idx_q   <= '0;
						phase_q    <= 1'b0;
						req_q.w    <= width;
						req_q.h    <= height;
						req_q.area <= AREA_W'(width) * AREA_W'(height);
					end
				end
				ST_SCAN: begin
					phase_q <= !phase_q;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (sts.found || (rd_idx_q == n_q)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!valid_s1_q && !sts.pipe_busy) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					result_valid_q  <= 1'b1;
					mode_index_q    <= SLOT_W'(chosen_idx);
					chosen_width_q  <= rd_data.w;
					chosen_height_q <= rd_data.h;
					exact_hit_q     <= (rd_data.w == req_q.w) && (rd_data.h == req_q.h);
					state_q         <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign ctl.clr       = accept && is_query;
	assign ctl.valid_s1  = valid_s1_q;
	assign idx_s1        = idx_s1_q;
	assign req           = req_q;
	assign result_valid  = result_valid_q;
	assign mode_index    = mode_index_q;
	assign chosen_width  = chosen_width_q;
	assign chosen_height = chosen_height_q;
	assign exact_hit     = exact_hit_q;

endmodule

>>> rtl/core/display_mode_best_match_top.sv
`timescale 1ns / 1ps
// Top level of the display mode best-match block: APB registers and core wiring.
//
//  channel   handshake                    payload
//  command   start & !busy                req_type, entry_index, width, height
//  result    result_valid (1-cycle word)  mode_index, chosen_width, chosen_height, exact_hit
//  config    psel & penable & pwrite      paddr, pwdata (prdata on read), pready tied high
//
//  A table write goes straight to the RAM on accept and busy stays low.
//  A query scans n = min(mode_count, MAX_MODES) entries, issuing one only on alternate scan
//  phases to suit the two-stage cross-product compare loop on the running best score;
//  result_valid rises after the scan, drain, fetch and result states, earlier on an exact
//  hit. busy covers the whole query.
//  The result receiver cannot stall; a new command is taken while the result word shows.
//  Reset clears the registers and control; the mode table has no reset and no clearing pass.
module display_mode_best_match_top import dmbm_pkg::*; #(
	parameter int MAX_MODES = MAX_MODES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic [SLOT_W-1:0]    entry_index,
	input  logic [DIM_BITS-1:0]  width,
	input  logic [DIM_BITS-1:0]  height,
	output logic                 result_valid,
	output logic [SLOT_W-1:0]    mode_index,
	output logic [DIM_BITS-1:0]  chosen_width,
	output logic [DIM_BITS-1:0]  chosen_height,
	output logic                 exact_hit,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready
);

	localparam int IDX_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;

	logic [CNT_REG_W-1:0] mode_count_q;
	host_lim_t            lim_q;
	logic                 apb_wr;

	logic                 mem_en;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_addr;
	mode_t                mem_wdata;
	mode_t                rd_data;
	scan_ctl_t            ctl;
	scan_sts_t            sts;
	logic [IDX_W-1:0]     idx_s1;
	logic [IDX_W-1:0]     chosen_idx;
	query_t               req;

	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_count_q <= '0;
			lim_q.max_w  <= '1;
			lim_q.max_h  <= '1;
		end else if (apb_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_MODE_COUNT: mode_count_q <= pwdata[CNT_REG_W-1:0];
				REG_HOST_MAX_W: lim_q.max_w  <= pwdata[DIM_BITS-1:0];
				REG_HOST_MAX_H: lim_q.max_h  <= pwdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_MODE_COUNT: prdata = APB_DW'(mode_count_q);
			REG_HOST_MAX_W: prdata = APB_DW'(lim_q.max_w);
			REG_HOST_MAX_H: prdata = APB_DW'(lim_q.max_h);
			default:        prdata = '0;
		endcase
	end

	dmbm_mem #(
		.DEPTH (MAX_MODES),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.en      (mem_en),
		.we      (mem_we),
		.addr    (mem_addr),
		.wr_data (mem_wdata),
		.rd_data (rd_data)
	);

	dmbm_score #(
		.IDX_W (IDX_W)
	) u_score (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.idx_s1     (idx_s1),
		.entry      (rd_data),
		.req        (req),
		.lim        (lim_q),
		.sts        (sts),
		.chosen_idx (chosen_idx)
	);

	dmbm_seq #(
		.MAX_MODES (MAX_MODES),
		.IDX_W     (IDX_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.entry_index   (entry_index),
		.width         (width),
		.height        (height),
		.mode_count    (mode_count_q),
		.mem_en        (mem_en),
		.mem_we        (mem_we),
		.mem_addr      (mem_addr),
		.mem_wdata     (mem_wdata),
		.rd_data       (rd_data),
		.ctl           (ctl),
		.idx_s1        (idx_s1),
		.req           (req),
		.sts           (sts),
		.chosen_idx    (chosen_idx),
		.result_valid  (result_valid),
		.mode_index    (mode_index),
		.chosen_width  (chosen_width),
		.chosen_height (chosen_height),
		.exact_hit     (exact_hit)
	);

endmodule

>>> tb/sv/display_mode_best_match_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the display mode best-match block: tracks table and registers, predicts picks.
module display_mode_best_match_checker import dmbm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic                req_type,
	input  logic [SLOT_W-1:0]   entry_index,
	input  logic [DIM_BITS-1:0] width,
	input  logic [DIM_BITS-1:0] height,
	input  logic                result_valid,
	input  logic [SLOT_W-1:0]   mode_index,
	input  logic [DIM_BITS-1:0] chosen_width,
	input  logic [DIM_BITS-1:0] chosen_height,
	input  logic                exact_hit,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	input  logic                pready,
	output int                  mismatches,
	output int                  open_queries,
	output int                  queries_seen,
	output int                  exact_seen,
	output int                  fallback_seen
);

	localparam int TABLE_DEPTH = MAX_MODES_DEF;

	typedef struct packed {
		logic [SLOT_W-1:0]   idx;
		logic [DIM_BITS-1:0] w;
		logic [DIM_BITS-1:0] h;
		logic                hit;
		logic                scored;
	} pick_t;

	logic [CNT_REG_W-1:0] scan_cfg;
	logic [DIM_BITS-1:0]  lim_w;
	logic [DIM_BITS-1:0]  lim_h;
	logic [DIM_BITS-1:0]  slot_w [TABLE_DEPTH];
	logic [DIM_BITS-1:0]  slot_h [TABLE_DEPTH];
	pick_t                expected_picks [$];
	pick_t                want;
	int                   errs;
	int                   n_query;
	int                   n_exact;
	int                   n_fallback;

	// Earliest exact match, else best IoU by cross-multiplication; entry 0 when nothing scores.
	function automatic pick_t best_pick(input logic [DIM_BITS-1:0] rw,
			input logic [DIM_BITS-1:0] rh);
		pick_t               p;
		int                  n;
		int                  i;
		logic [DIM_BITS-1:0] w;
		logic [DIM_BITS-1:0] h;
		logic [DIM_BITS-1:0] mw;
		logic [DIM_BITS-1:0] mh;
		logic [AREA_W-1:0]   inter;
		logic [AREA_W-1:0]   best_i;
		logic [UNI_W-1:0]    uni;
		logic [UNI_W-1:0]    best_u;
		logic [PROD_W-1:0]   lhs;
		logic [PROD_W-1:0]   rhs;
		p = '0;
		best_i = '0;
		best_u = 1;
		n = (scan_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_cfg);
		for (i = 0; i < n; i++) begin
			w = slot_w[i];
			h = slot_h[i];
			if (w == 0 || h == 0 || w > lim_w || h > lim_h)
				continue;
			if (w == rw && h == rh) begin
				p.idx = SLOT_W'(i);
				p.scored = 1'b1;
				break;
			end
			mw = (w < rw) ? w : rw;
			mh = (h < rh) ? h : rh;
			// operands widen to the target width before the multiply
			inter = mw * mh;
			uni = w * h + rw * rh - inter;
			lhs = inter * best_u;
			rhs = best_i * uni;
			if (lhs > rhs) begin
				best_i = inter;
				best_u = uni;
				p.idx = SLOT_W'(i);
				p.scored = 1'b1;
			end
		end
		p.w = slot_w[p.idx];
		p.h = slot_h[p.idx];
		p.hit = (p.w == rw && p.h == rh);
		return p;
	endfunction

	task automatic check_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, got_v);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cfg = '0;
			lim_w = '1;
			lim_h = '1;
			expected_picks.delete();
			errs = 0;
			n_query = 0;
			n_exact = 0;
			n_fallback = 0;
			mismatches <= 0;
			open_queries <= 0;
			queries_seen <= 0;
			exact_seen <= 0;
			fallback_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_AW-1:2]))
					REG_MODE_COUNT: scan_cfg = pwdata[CNT_REG_W-1:0];
					REG_HOST_MAX_W: lim_w = pwdata[DIM_BITS-1:0];
					REG_HOST_MAX_H: lim_h = pwdata[DIM_BITS-1:0];
					default: ;
				endcase
			end
			if (result_valid) begin
				if (expected_picks.size() == 0) begin
					$display("%0t: result word with nothing expected: idx %0d %0dx%0d hit %0b",
						$time, mode_index, chosen_width, chosen_height, exact_hit);
					errs++;
				end else begin
					want = expected_picks.pop_front();
					check_field("mode_index", want.idx, mode_index);
					check_field("chosen_width", want.w, chosen_width);
					check_field("chosen_height", want.h, chosen_height);
					check_field("exact_hit", want.hit, exact_hit);
				end
			end
			if (start && !busy) begin
				if (req_kind_t'(req_type) == REQ_QUERY) begin
					want = best_pick(width, height);
					expected_picks.push_back(want);
					n_query++;
					if (want.hit)
						n_exact++;
					if (!want.scored)
						n_fallback++;
				end else begin
					slot_w[entry_index] = width;
					slot_h[entry_index] = height;
				end
			end
			mismatches <= errs;
			open_queries <= expected_picks.size();
			queries_seen <= n_query;
			exact_seen <= n_exact;
			fallback_seen <= n_fallback;
		end
	end

endmodule

>>> tb/sv/display_mode_best_match_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the display mode best-match block: stimulus, register setup and verdict.
module display_mode_best_match_top_tb;
	import dmbm_pkg::*;

	localparam int DEPTH = MAX_MODES_DEF;
	localparam int LIMIT = 1000000;
	localparam int PHASE_ITEMS = 355;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                req_type;
	logic [SLOT_W-1:0]   entry_index;
	logic [DIM_BITS-1:0] width;
	logic [DIM_BITS-1:0] height;
	logic                result_valid;
	logic [SLOT_W-1:0]   mode_index;
	logic [DIM_BITS-1:0] chosen_width;
	logic [DIM_BITS-1:0] chosen_height;
	logic                exact_hit;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	int mismatches;
	int open_queries;
	int queries_seen;
	int exact_seen;
	int fallback_seen;

	int          cycles = 0;
	int          idle_pct;
	int          cur_count;
	int          writes_sent;
	int          reg_writes;
	logic [31:0] shadow [DEPTH];

	display_mode_best_match_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.entry_index  (entry_index),
		.width        (width),
		.height       (height),
		.result_valid (result_valid),
		.mode_index   (mode_index),
		.chosen_width (chosen_width),
		.chosen_height(chosen_height),
		.exact_hit    (exact_hit),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	display_mode_best_match_checker pick_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.entry_index  (entry_index),
		.width        (width),
		.height       (height),
		.result_valid (result_valid),
		.mode_index   (mode_index),
		.chosen_width (chosen_width),
		.chosen_height(chosen_height),
		.exact_hit    (exact_hit),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.open_queries (open_queries),
		.queries_seen (queries_seen),
		.exact_seen   (exact_seen),
		.fallback_seen(fallback_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [DIM_BITS-1:0] edge_dim();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFE;
			default: return 16'hFFFF;
		endcase
	endfunction

	// {width, height}: common screen modes, tiny sizes for ties, edge values, anything
	function automatic logic [31:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 35) begin
			case ($urandom_range(7))
				0: return {16'd640, 16'd480};
				1: return {16'd800, 16'd600};
				2: return {16'd1024, 16'd768};
				3: return {16'd1280, 16'd720};
				4: return {16'd1366, 16'd768};
				5: return {16'd1920, 16'd1080};
				6: return {16'd2560, 16'd1440};
				default: return {16'd3840, 16'd2160};
			endcase
		end
		if (r < 60)
			return {16'($urandom_range(1, 8)), 16'($urandom_range(1, 8))};
		if (r < 70)
			return {edge_dim(), edge_dim()};
		return $urandom();
	endfunction

	function automatic logic [DIM_BITS-1:0] pick_limit();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 16'hFFFF;
		if (r < 62)
			return 16'd0;
		if (r < 80)
			return 16'($urandom_range(1, 16));
		return 16'($urandom_range(17, 4000));
	endfunction

	function automatic int scan_len();
		return (cur_count > DEPTH) ? DEPTH : cur_count;
	endfunction

	// mostly stored modes or near misses, so exact hits and close scores happen
	function automatic logic [31:0] pick_request();
		int          r;
		logic [31:0] q;
		r = $urandom_range(99);
		q = shadow[$urandom_range(scan_len() > 0 ? scan_len() - 1 : 0)];
		if (r < 40)
			return q;
		if (r < 65) begin
			q[31:16] = q[31:16] + 16'($urandom_range(6)) - 16'd3;
			q[15:0] = q[15:0] + 16'($urandom_range(6)) - 16'd3;
			return q;
		end
		return pick_size();
	endfunction

	task automatic send_word(input req_kind_t kind, input logic [SLOT_W-1:0] slot,
			input logic [31:0] dims);
		start <= 1'b1;
		req_type <= kind;
		entry_index <= slot;
		width <= dims[31:16];
		height <= dims[15:0];
		do @(posedge clk); while (busy);
		if (kind == REQ_WRITE) begin
			shadow[slot] = dims;
			writes_sent++;
		end
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			req_type <= 1'($urandom_range(1));
			entry_index <= SLOT_W'($urandom());
			width <= DIM_BITS'($urandom());
			height <= DIM_BITS'($urandom());
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// hold off until every query has been answered, then let a trailing write finish
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (open_queries != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t r, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
	endtask

	task automatic configure(input int cnt, input int mw, input int mh);
		settle();
		reg_write(REG_MODE_COUNT, cnt);
		reg_write(REG_HOST_MAX_W, mw);
		reg_write(REG_HOST_MAX_H, mh);
		cur_count = cnt;
	endtask

	initial begin
		int i;
		int phase;
		int left;
		int seg;
		int r;
		int cnt;
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_WRITE;
		entry_index <= '0;
		width <= '0;
		height <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		idle_pct = 23;
		cur_count = 0;
		writes_sent = 0;
		reg_writes = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table has no reset: fill every slot before the first query
		for (i = 0; i < DEPTH; i++)
			send_word(REQ_WRITE, SLOT_W'(i), pick_size());

		// count of zero after reset: falls back to slot 0
		send_word(REQ_QUERY, '0, {16'd1920, 16'd1080});
		send_word(REQ_WRITE, 6'd0, {16'hFFFF, 16'hFFFF});
		send_word(REQ_WRITE, 6'd1, {16'd1920, 16'd1080});
		send_word(REQ_WRITE, 6'd2, {16'd1920, 16'd1080});
		send_word(REQ_WRITE, 6'd3, {16'd0, 16'd600});
		send_word(REQ_WRITE, 6'd4, {16'd1280, 16'd0});
		send_word(REQ_WRITE, 6'd5, {16'd1, 16'd1});
		send_word(REQ_WRITE, 6'd6, {16'd3840, 16'd2160});
		configure(7, 16'hFFFF, 16'hFFFF);
		send_word(REQ_QUERY, 6'd63, {16'd1920, 16'd1080});
		send_word(REQ_QUERY, '0, {16'hFFFF, 16'hFFFF});
		send_word(REQ_QUERY, '0, {16'd0, 16'd0});
		// slots 1 and 2 tie; earliest wins
		send_word(REQ_QUERY, '0, {16'd1600, 16'd900});
		send_word(REQ_QUERY, '0, {16'd0, 16'd600});
		send_word(REQ_QUERY, '0, {16'hFFFF, 16'd1});
		configure(7, 1920, 1080);
		send_word(REQ_QUERY, '0, {16'd3840, 16'd2160});
		send_word(REQ_QUERY, '0, {16'hFFFF, 16'hFFFF});
		// limits of zero skip everything; slot 0 still reports an exact hit
		configure(7, 0, 0);
		send_word(REQ_QUERY, '0, {16'hFFFF, 16'hFFFF});
		configure(127, 16'hFFFF, 16'hFFFF);
		send_word(REQ_QUERY, '0, {16'd1, 16'd1});
		send_word(REQ_QUERY, '0, {16'd1366, 16'd768});
		configure(64, 16'hFFFF, 16'hFFFF);
		send_word(REQ_QUERY, '0, {16'd800, 16'd600});

		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 23 : (phase == 1) ? 62 : 0;
			left = PHASE_ITEMS;
			while (left > 0) begin
				r = $urandom_range(99);
				cnt = (r < 10) ? 64 : (r < 16) ? $urandom_range(65, 127) :
					(r < 20) ? 0 : (r < 60) ? $urandom_range(1, 8) : $urandom_range(9, 63);
				configure(cnt, pick_limit(), pick_limit());
				seg = $urandom_range(20, 70);
				for (i = 0; i < seg && left > 0; i++) begin
					if ($urandom_range(99) < 55) begin
						send_word(REQ_WRITE, ($urandom_range(1) && scan_len() > 0) ?
							SLOT_W'($urandom_range(scan_len() - 1)) : SLOT_W'($urandom()),
							pick_size());
					end else begin
						send_word(REQ_QUERY, SLOT_W'($urandom()), pick_request());
						if ($urandom_range(99) < 4)
							settle();
					end
					left--;
				end
			end
		end

		settle();
		repeat (2 * DEPTH + 10) @(posedge clk);
		$display("Covered %0d table writes and %0d register writes over three idle mixes.",
			writes_sent, reg_writes);
		$display("Checked %0d queries: %0d exact hits, %0d with no scoring entry.",
			queries_seen, exact_seen, fallback_seen);
		if (mismatches == 0 && open_queries == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/dmbm_pkg.sv
rtl/core/dmbm_mem.sv
rtl/core/dmbm_score.sv
rtl/core/dmbm_seq.sv
rtl/core/display_mode_best_match_top.sv
tb/sv/display_mode_best_match_checker.sv
tb/sv/display_mode_best_match_top_tb.sv
